>>> sv/mdv_pkg.sv
// Shared types and constants for the 64x32/32 multiply-divide pipeline.
package mdv_pkg;

	localparam int WordBits = 32;
	localparam int ValueBits = 64;
	localparam int ProdBits = ValueBits + WordBits;
	localparam int DivBitsPerStage = 4;
	localparam int DivStages = ProdBits / DivBitsPerStage;
	localparam int InDataBits = ValueBits + 2 * WordBits;

	// Divider state carried from stage to stage
	typedef struct packed {
		logic [WordBits-1:0] rem;  // partial remainder, below the divisor
		logic [ProdBits-1:0] work; // dividend bits shifting out, quotient bits shifting in
		logic [WordBits-1:0] dvs;  // divisor
		logic                dz;   // divisor was zero
	} div_pipe_t;

endpackage

>>> sv/mdv_mul.sv
// Two-stage multiplier front end: partial products, then the 96-bit product sum.
module mdv_mul
	import mdv_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [ValueBits-1:0]  value,
	input  logic [WordBits-1:0]   multiplier,
	input  logic [WordBits-1:0]   divisor,
	output logic                  out_valid,
	input  logic                  out_ready,
	output div_pipe_t             out_data
);

	logic                 valid_s1;
	logic                 valid_s2;
	logic                 ready_s1;
	logic                 ready_s2;
	logic [2*WordBits-1:0] plo_s1;
	logic [2*WordBits-1:0] phi_s1;
	logic [WordBits-1:0]  dvs_s1;
	logic                 dz_s1;
	div_pipe_t            data_s2;

	// A stage loads when it is empty or its beat moves on
	assign ready_s2 = !valid_s2 || out_ready;
	assign ready_s1 = !valid_s1 || ready_s2;
	assign in_ready = ready_s1;

	// Advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (ready_s1) valid_s1 <= in_valid;
			if (ready_s2) valid_s2 <= valid_s1;
		end
	end

	// Stage 1: two 32x32 partial products
	always_ff @(posedge clk) begin
		if (in_valid && ready_s1) begin
			plo_s1 <= value[WordBits-1:0] * multiplier;
			phi_s1 <= value[ValueBits-1:WordBits] * multiplier;
			dvs_s1 <= divisor;
			dz_s1  <= (divisor == '0);
		end
	end

	// Stage 2: join the partial products into the 96-bit product
	always_ff @(posedge clk) begin
		if (valid_s1 && ready_s2) begin
			data_s2.rem  <= '0;
			data_s2.work <= {phi_s1, {WordBits{1'b0}}} + {{WordBits{1'b0}}, plo_s1};
			data_s2.dvs  <= dvs_s1;
			data_s2.dz   <= dz_s1;
		end
	end

	assign out_valid = valid_s2;
	assign out_data  = data_s2;

endmodule

>>> sv/mdv_div_stage.sv
// One divider stage: a few restoring-division steps and a pipeline register.
module mdv_div_stage
	import mdv_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  div_pipe_t in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output div_pipe_t out_data
);

	logic                valid_s1;
	div_pipe_t           data_s1;
	div_pipe_t           nxt;
	logic [WordBits-1:0] rem;
	logic [ProdBits-1:0] work;
	logic [WordBits:0]   trial;

	assign in_ready = !valid_s1 || out_ready;

	// Shift one dividend bit into the remainder per step, subtract when it fits
	always_comb begin
		rem   = in_data.rem;
		work  = in_data.work;
		trial = '0;
		for (int i = 0; i < DivBitsPerStage; i++) begin
			trial = {rem, work[ProdBits-1]};
			work  = {work[ProdBits-2:0], 1'b0};
			if (trial >= {1'b0, in_data.dvs}) begin
				rem     = WordBits'(trial - {1'b0, in_data.dvs});
				work[0] = 1'b1;
			end else begin
				rem = trial[WordBits-1:0];
			end
		end
		nxt      = in_data;
		nxt.rem  = rem;
		nxt.work = work;
	end

	// Advance valid bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// Load payload on an accepted beat
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_s1 <= nxt;
		end
	end

	assign out_valid = valid_s1;
	assign out_data  = data_s1;

endmodule

>>> sv/muldiv_64x32_by_32.sv
// Top level of the pipelined (value * multiplier) / divisor unit.
//
// Input stream: one beat carries value, multiplier and divisor; the beat is
// taken when s_axis_tvalid and s_axis_tready are both high.
// Output stream: one beat per input beat, in order, with the low 64 bits of
// the 96-bit quotient in m_axis_tdata and two flags in m_axis_tuser. When the
// quotient needs more than 64 bits, the upper bits are dropped and
// high_truncated is set. A zero divisor gives an all-ones quotient and sets
// divide_by_zero.
// Pipeline: two multiplier stages (partial products, product sum) and 24
// divider stages of 4 quotient bits.
// Throughput: one beat per cycle while the receiver is ready; every stage holds its own valid bit.
// Reset clears all valid bits; the pipeline is then empty and ready.
// When the receiver stalls, each stage holds its beat while the stages
// behind it fill their empty slots, so the input keeps taking beats until
// the whole pipeline is full.
module muldiv_64x32_by_32
	import mdv_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [InDataBits-1:0] s_axis_tdata,  // value[63:0], multiplier, divisor
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [ValueBits-1:0]  m_axis_tdata,  // quotient
	output logic [1:0]            m_axis_tuser   // high_truncated, divide_by_zero
);

	logic      dvalid [DivStages+1];
	logic      dready [DivStages+1];
	div_pipe_t ddata  [DivStages+1];
	div_pipe_t last;

	// Multiply front end
	mdv_mul u_mul (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.value      (s_axis_tdata[ValueBits-1:0]),
		.multiplier (s_axis_tdata[ValueBits+WordBits-1:ValueBits]),
		.divisor    (s_axis_tdata[ValueBits+2*WordBits-1:ValueBits+WordBits]),
		.out_valid  (dvalid[0]),
		.out_ready  (dready[0]),
		.out_data   (ddata[0])
	);

	// Divider chain
	for (genvar g = 0; g < DivStages; g++) begin : g_div
		mdv_div_stage u_stage (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (dvalid[g]),
			.in_ready  (dready[g]),
			.in_data   (ddata[g]),
			.out_valid (dvalid[g+1]),
			.out_ready (dready[g+1]),
			.out_data  (ddata[g+1])
		);
	end

	assign dready[DivStages] = m_axis_tready;
	assign last = ddata[DivStages];

	// Drive the output beat; override the quotient on a zero divisor
	assign m_axis_tvalid   = dvalid[DivStages];
	assign m_axis_tdata    = last.dz ? {ValueBits{1'b1}} : last.work[ValueBits-1:0];
	assign m_axis_tuser[0] = !last.dz && (|last.work[ProdBits-1:ValueBits]);
	assign m_axis_tuser[1] = last.dz;

endmodule

>>> test/tb_top.sv
// Self-checking testbench for the muldiv_64x32_by_32 multiply-divide pipeline.
module tb_top
	import mdv_pkg::*;
();

	localparam int ClkHalf    = 5;
	localparam int ResetCyc   = 11;
	localparam int NumRandom  = 950;
	localparam int IdlePct    = 18;
	localparam int DrainCyc   = 40;
	localparam int CycleLimit = 200000;
	localparam int PausePoint = 300;
	localparam int CalmFirst  = 500;
	localparam int CalmLast   = 650;

	// Expected outcome of one operand set
	typedef struct packed {
		logic [ValueBits-1:0] quot;
		logic                 trunc;
		logic                 dz;
	} quot_res_t;

	// One row of the directed table; known rows carry their result
	typedef struct packed {
		logic [ValueBits-1:0] value;
		logic [WordBits-1:0]  mult;
		logic [WordBits-1:0]  dvs;
		logic                 known;
		quot_res_t            res;
	} op_row_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	logic [InDataBits-1:0] s_axis_tdata;  // value[63:0], multiplier, divisor
	logic                  m_axis_tvalid;
	logic                  m_axis_tready;
	logic [ValueBits-1:0]  m_axis_tdata;  // quotient
	logic [1:0]            m_axis_tuser;  // high_truncated, divide_by_zero

	quot_res_t beat_res;
	quot_res_t pending_quot[$];
	op_row_t   dir_rows[$];
	logic      calm;
	int        errors;
	int        cycle_cnt;
	int        n_checked;
	int        n_trunc;
	int        n_dz;

	muldiv_64x32_by_32 DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser)
	);

	always #ClkHalf clk = ~clk;

	// Scale value by multiplier over divisor through a 96-bit product
	function automatic quot_res_t scale_div(logic [ValueBits-1:0] value,
			logic [WordBits-1:0] mult, logic [WordBits-1:0] dvs);
		logic [63:0] lo_prod;
		logic [63:0] hi_prod;
		logic [63:0] q_hi;
		logic [63:0] rem;
		logic [63:0] q_lo;
		quot_res_t   r;
		if (dvs == '0) begin
			r.quot  = '1;
			r.trunc = 1'b0;
			r.dz    = 1'b1;
			return r;
		end
		lo_prod = {32'd0, value[31:0]} * {32'd0, mult};
		hi_prod = {32'd0, value[63:32]} * {32'd0, mult} + {32'd0, lo_prod[63:32]};
		q_hi    = hi_prod / {32'd0, dvs};
		rem     = hi_prod % {32'd0, dvs};
		q_lo    = {rem[31:0], lo_prod[31:0]} / {32'd0, dvs};
		r.quot  = {q_hi[31:0], q_lo[31:0]};
		r.trunc = (q_hi[63:32] != '0);
		r.dz    = 1'b0;
		return r;
	endfunction

	// Present one beat after a random gap and hold it until taken
	task automatic send_beat(logic [ValueBits-1:0] value, logic [WordBits-1:0] mult,
			logic [WordBits-1:0] dvs, quot_res_t res);
		while (!calm && $urandom_range(99) < IdlePct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {dvs, mult, value};
		beat_res      <= res;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
	endtask

	// Record the expected result of every accepted input beat
	always @(posedge clk) begin
		if (arst_n && s_axis_tvalid && s_axis_tready)
			pending_quot.push_back(beat_res);
	end

	// Stall the output side at random, except during the calm stretch
	always @(posedge clk) begin
		m_axis_tready <= calm || ($urandom_range(99) >= IdlePct);
	end

	// Compare each output beat with the oldest expectation
	always @(posedge clk) begin
		quot_res_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_quot.size() == 0) begin
				errors++;
				$display("%0t: unexpected beat quot=%h user=%b", $time,
					m_axis_tdata, m_axis_tuser);
			end else begin
				want = pending_quot.pop_front();
				n_checked++;
				if (want.trunc) n_trunc++;
				if (want.dz) n_dz++;
				if (m_axis_tdata !== want.quot) begin
					errors++;
					$display("%0t: quotient expected %h actual %h", $time,
						want.quot, m_axis_tdata);
				end
				if (m_axis_tuser[0] !== want.trunc) begin
					errors++;
					$display("%0t: high_truncated expected %b actual %b", $time,
						want.trunc, m_axis_tuser[0]);
				end
				if (m_axis_tuser[1] !== want.dz) begin
					errors++;
					$display("%0t: divide_by_zero expected %b actual %b", $time,
						want.dz, m_axis_tuser[1]);
				end
			end
		end
	end

	// Stop a hung run
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= CycleLimit) begin
			$display("%0t: cycle limit reached, %0d results outstanding", $time,
				pending_quot.size());
			$display("tb_top NOT OK");
			$finish;
		end
	end

	initial begin
		logic [ValueBits-1:0] value;
		logic [WordBits-1:0]  mult;
		logic [WordBits-1:0]  dvs;
		int                   kind;
		op_row_t              row;

		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		m_axis_tready = 1'b0;
		beat_res      = '0;
		calm          = 1'b0;
		errors        = 0;
		cycle_cnt     = 0;
		n_checked     = 0;
		n_trunc       = 0;
		n_dz          = 0;

		// Directed rows: value, multiplier, divisor, known, {quotient, trunc, dz}
		dir_rows.push_back('{64'd0, 32'd0, 32'd0, 1'b1, '{'1, 1'b0, 1'b1}});
		dir_rows.push_back('{'1, '1, 32'd0, 1'b1, '{'1, 1'b0, 1'b1}});
		dir_rows.push_back('{64'd5, 32'd5, 32'd0, 1'b1, '{'1, 1'b0, 1'b1}});
		dir_rows.push_back('{64'd0, '1, '1, 1'b1, '{64'd0, 1'b0, 1'b0}});
		dir_rows.push_back('{'1, 32'd0, 32'd1, 1'b1, '{64'd0, 1'b0, 1'b0}});
		dir_rows.push_back('{'1, 32'd1, 32'd1, 1'b1, '{'1, 1'b0, 1'b0}});
		dir_rows.push_back('{'1, '1, '1, 1'b1, '{'1, 1'b0, 1'b0}});
		dir_rows.push_back('{'1, 32'd1, 32'd2, 1'b1,
			'{64'h7fff_ffff_ffff_ffff, 1'b0, 1'b0}});
		dir_rows.push_back('{64'h1_0000_0000, 32'd1, 32'd1, 1'b1,
			'{64'h1_0000_0000, 1'b0, 1'b0}});
		// Product of exactly 2^64 over one: low 64 bits of the quotient are zero, high_truncated set
		dir_rows.push_back('{64'h8000_0000_0000_0000, 32'd2, 32'd1, 1'b1,
			'{64'd0, 1'b1, 1'b0}});
		dir_rows.push_back('{64'd100, 32'd3, 32'd7, 1'b1, '{64'd42, 1'b0, 1'b0}});
		dir_rows.push_back('{64'd1, 32'd1, '1, 1'b1, '{64'd0, 1'b0, 1'b0}});
		dir_rows.push_back('{64'hffff_ffff, '1, '1, 1'b1,
			'{64'hffff_ffff, 1'b0, 1'b0}});
		dir_rows.push_back('{'1, '1, 32'd1, 1'b0, '0});
		dir_rows.push_back('{'1, '1, 32'h8000_0000, 1'b0, '0});
		dir_rows.push_back('{64'd12345, 32'd7, 32'd3, 1'b0, '0});
		dir_rows.push_back('{64'h5555_5555_5555_5555, 32'haaaa_aaaa, 32'h5555_5555,
			1'b0, '0});
		dir_rows.push_back('{64'haaaa_aaaa_aaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa,
			1'b0, '0});
		dir_rows.push_back('{64'h0123_4567_89ab_cdef, 32'hfedc_ba98, 32'h0000_0003,
			1'b0, '0});

		repeat (ResetCyc) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Walk the directed table
		foreach (dir_rows[i]) begin
			row = dir_rows[i];
			send_beat(row.value, row.mult, row.dvs,
				row.known ? row.res : scale_div(row.value, row.mult, row.dvs));
		end

		// Random operand sets, biased toward the interesting regions
		for (int n = 0; n < NumRandom; n++) begin
			if (n == PausePoint) begin
				s_axis_tvalid <= 1'b0;
				do @(posedge clk); while (pending_quot.size() != 0);
			end
			calm  = (n >= CalmFirst && n < CalmLast);
			kind  = $urandom_range(9);
			value = {$urandom, $urandom};
			mult  = $urandom;
			dvs   = $urandom;
			case (kind)
				0: dvs = '0;
				1: dvs = $urandom_range(255, 1);
				2: begin
					value[63:32] = $urandom_range(1) ? '1 : '0;
					value[31:0]  = $urandom_range(1) ? '1 : '0;
					mult         = $urandom_range(1) ? '1 : mult;
				end
				3, 4, 5: begin
					if (dvs == '0) dvs = 32'd1;
					mult = $urandom_range(dvs, 0);
				end
				default: ;
			endcase
			send_beat(value, mult, dvs, scale_div(value, mult, dvs));
		end
		s_axis_tvalid <= 1'b0;
		calm = 1'b0;

		// Drain the pipeline, then watch for stray beats
		while (pending_quot.size() != 0)
			@(posedge clk);
		repeat (DrainCyc) @(posedge clk);
		if (pending_quot.size() != 0) begin
			errors++;
			$display("%0t: %0d expected results never arrived", $time,
				pending_quot.size());
		end

		$display("Checked %0d quotients: %0d with truncated upper word, %0d zero divisors.",
			n_checked, n_trunc, n_dz);
		$display("Covered field extremes, random stalls on both sides and a full drain.");
		if (errors == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end

endmodule

>>> sim.f
sv/mdv_pkg.sv
sv/mdv_mul.sv
sv/mdv_div_stage.sv
sv/muldiv_64x32_by_32.sv
test/tb_top.sv
